### hw/rtl/nfcc_pkg.sv
// ----------------------------------------------------------------------------
// NOR flash command controller package
// Geometry, mode and command codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package nfcc_pkg;

	localparam int BANK_COUNT   = 64;
	localparam int BANK_BYTES   = 8192;
	localparam int SECTOR_BANKS = 8;
	localparam int CELL_DEPTH   = BANK_COUNT * BANK_BYTES;
	localparam int CELL_AW      = $clog2(CELL_DEPTH);
	localparam int PEND_MAX     = 64;

	// access commands
	localparam logic [1:0] CMD_BUS_RD = 2'd0;
	localparam logic [1:0] CMD_BUS_WR = 2'd1;
	localparam logic [1:0] CMD_MON_RD = 2'd2;
	localparam logic [1:0] CMD_MON_WR = 2'd3;

	// modes
	localparam logic [2:0] MODE_READ       = 3'd0;
	localparam logic [2:0] MODE_AUTOSEL    = 3'd1;
	localparam logic [2:0] MODE_PROGRAM    = 3'd2;
	localparam logic [2:0] MODE_CHIP_ERASE = 3'd3;
	localparam logic [2:0] MODE_SECT_ERASE = 3'd4;
	localparam logic [2:0] MODE_SECT_SUSP  = 3'd5;
	localparam logic [2:0] MODE_CHIP_SUSP  = 3'd6;

	// configuration register indexes
	localparam logic REG_ERASE_DELAY    = 1'b0;
	localparam logic REG_UNLOCK_TIMEOUT = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic take;       // latch input item
		logic fill_all;   // write 0xFF at sweep address, advance
		logic pend_load;  // latch sector base from pending list
		logic fill_sect;  // write 0xFF in current sector bank, advance
		logic pend_next;  // next pending entry
		logic commit;     // erase finished: back to read mode
		logic exec;       // carry out the access, load result
	} nfcc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic chip_due;
		logic sect_due;
		logic pend_empty;
		logic fill_last;
		logic sect_last;
		logic pend_last;
		logic out_busy;
	} nfcc_stat_t;

endpackage

### hw/rtl/nor_flash_command_controller_top.sv
// An item is taken, checked for a due erase, held while a result waits, then executed;
// no new item is taken before that. A due chip erase fills every cell with 0xFF, one cell
// a cycle through the single RAM write port; a due sector erase fills each pending sector.
// After reset the cell array is set to 0xFF by a pass over every cell; no item is taken
// during it, configuration writes are. Registers reset to 80 and 200.
// ----------------------------------------------------------------------------
// NOR flash command controller
// JEDEC style command set over a 64 x 8 KB byte array, stream item interface.
// ----------------------------------------------------------------------------
module nor_flash_command_controller_top import nfcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// item in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // command[1:0] bank[7:2] offset[20:8]
	                                   // write_data[28:21] stamp[60:29] zero[63:61]
	// result out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // read_data[7:0] mode_now[10:8] zero[15:11]
	// configuration writes
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	nfcc_cmd_t  cmd;
	nfcc_stat_t stat;
	logic [7:0] read_data;
	logic [2:0] mode_now;

	// sequencer: erase walk and access steps
	nfcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: arrays, mode/unlock state, result register
	nfcc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_command    (s_axis_tdata[1:0]),
		.in_bank       (s_axis_tdata[7:2]),
		.in_offset     (s_axis_tdata[20:8]),
		.in_write_data (s_axis_tdata[28:21]),
		.in_stamp      (s_axis_tdata[60:29]),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_read_data (read_data),
		.out_mode_now  (mode_now)
	);

	assign m_axis_tdata = {5'd0, mode_now, read_data};

	// one item at a time: no second accept right after one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("item taken while previous one in flight");

	// a result only comes from an execution step
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(cmd.exec))
		else $error("result without execution");

	// reported mode is always a real mode
	a_mode_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[10:8] != 3'd7))
		else $error("bad mode in result");

	// execution never overwrites a waiting result
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !stat.out_busy)
		else $error("result overwritten");

endmodule

### hw/rtl/nfcc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module nfcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/nfcc_ctrl.sv
// ----------------------------------------------------------------------------
// NOR flash command controller sequencer
// Steps each item through erase commit, cell read and execution.
// ----------------------------------------------------------------------------
module nfcc_ctrl import nfcc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  nfcc_stat_t stat,
	output nfcc_cmd_t  cmd
);

	localparam logic [3:0] ST_INIT  = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_CHECK = 4'd2;
	localparam logic [3:0] ST_CHIP  = 4'd3;
	localparam logic [3:0] ST_PREQ  = 4'd4;
	localparam logic [3:0] ST_PLOAD = 4'd5;
	localparam logic [3:0] ST_SECT  = 4'd6;
	localparam logic [3:0] ST_OP    = 4'd7;
	localparam logic [3:0] ST_EXEC  = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_n;

	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_INIT: begin
				cmd.fill_all = 1'b1;
				if (stat.fill_last) begin
					state_n = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_n  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.chip_due) begin
					state_n = ST_CHIP;
				end else if (stat.sect_due) begin
					if (stat.pend_empty) begin
						cmd.commit = 1'b1;
						state_n    = ST_OP;
					end else begin
						state_n = ST_PREQ;
					end
				end else begin
					state_n = ST_OP;
				end
			end
			ST_CHIP: begin
				cmd.fill_all = 1'b1;
				if (stat.fill_last) begin
					cmd.commit = 1'b1;
					state_n    = ST_OP;
				end
			end
			ST_PREQ: state_n = ST_PLOAD;
			ST_PLOAD: begin
				cmd.pend_load = 1'b1;
				state_n       = ST_SECT;
			end
			ST_SECT: begin
				cmd.fill_sect = 1'b1;
				if (stat.sect_last) begin
					cmd.pend_next = 1'b1;
					if (stat.pend_last) begin
						cmd.commit = 1'b1;
						state_n    = ST_OP;
					end else begin
						state_n = ST_PREQ;
					end
				end
			end
			ST_OP: begin
				if (!stat.out_busy) begin
					state_n = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_n  = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

### hw/rtl/nfcc_dp.sv
// ----------------------------------------------------------------------------
// NOR flash command controller datapath
// Cell array, pending sector list, mode and unlock state, result register.
// ----------------------------------------------------------------------------
module nfcc_dp import nfcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  nfcc_cmd_t   cmd,
	output nfcc_stat_t  stat,
	input  logic [1:0]  in_command,
	input  logic [5:0]  in_bank,
	input  logic [12:0] in_offset,
	input  logic [7:0]  in_write_data,
	input  logic [31:0] in_stamp,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_read_data,
	output logic [2:0]  out_mode_now
);

	localparam logic [2:0] UL_IDLE   = 3'd0;
	localparam logic [2:0] UL_AA     = 3'd1;
	localparam logic [2:0] UL_55     = 3'd2;
	localparam logic [2:0] UL_80     = 3'd3;
	localparam logic [2:0] UL_80AA   = 3'd4;
	localparam logic [2:0] UL_8055   = 3'd5;
	localparam logic [2:0] UL_LOCKED = 3'd6;

	localparam logic [6:0]  BANK_COUNT_V = 7'(BANK_COUNT);
	localparam logic [13:0] BANK_BYTES_V = 14'(BANK_BYTES);
	localparam logic [6:0]  PEND_MAX_V   = 7'(PEND_MAX);

	// latched item
	logic [1:0]  cmd_q;
	logic [5:0]  bank_q;
	logic [12:0] off_q;
	logic [7:0]  data_q;
	logic [31:0] stamp_q;

	// protocol state
	logic [15:0] delay_q;
	logic [15:0] timeout_q;
	logic [2:0]  mode_q;
	logic [2:0]  step_q;
	logic        tog_q;
	logic [31:0] last_q;
	logic [6:0]  cnt_q;

	// erase walk
	logic [CELL_AW-1:0] sweep_q;
	logic [6:0]         p_q;
	logic [5:0]         base_q;
	logic [5:0]         i_q;
	logic [12:0]        soff_q;
	logic [5:0]         sbank;

	logic               out_valid_q;
	logic [7:0]         out_rd_q;
	logic [2:0]         out_mode_q;

	logic [7:0]         cell_rd;
	logic [5:0]         pend_rd;
	logic               cell_we;
	logic [CELL_AW-1:0] cell_wa;
	logic [7:0]         cell_wd;
	logic [CELL_AW-1:0] item_addr;
	logic [CELL_AW-1:0] sect_addr;
	logic               in_range;
	logic               commit_due;

	// execution results
	logic [7:0] rd_n;
	logic [2:0] mode_n;
	logic [2:0] step_n;
	logic       tog_n;
	logic [6:0] cnt_n;
	logic       ex_cell_we;
	logic       pend_we;
	logic [5:0] pend_wa;
	logic       is555;
	logic       is2aa;

	function automatic logic over(input logic [31:0] stamp, input logic [31:0] last,
			input logic [15:0] limit);
		logic [31:0] d;
		d = stamp - last;
		return !d[31] && (d > {16'd0, limit});
	endfunction

	function automatic logic [CELL_AW-1:0] caddr(input logic [5:0] b, input logic [12:0] o);
		return CELL_AW'(b) * CELL_AW'(BANK_BYTES) + CELL_AW'(o);
	endfunction

	assign in_range   = ({1'b0, bank_q} < BANK_COUNT_V) && ({1'b0, off_q} < BANK_BYTES_V);
	assign item_addr  = caddr(bank_q, off_q);
	assign sbank      = base_q + i_q;
	assign sect_addr  = caddr(sbank, soff_q);
	assign commit_due = over(stamp_q, last_q, delay_q);
	assign is555      = (off_q == 13'h555);
	assign is2aa      = (off_q == 13'h2AA);

	assign stat.chip_due   = (mode_q == MODE_CHIP_ERASE) && commit_due;
	assign stat.sect_due   = (mode_q == MODE_SECT_ERASE) && commit_due;
	assign stat.pend_empty = (cnt_q == 7'd0);
	assign stat.fill_last  = (sweep_q == CELL_AW'(CELL_DEPTH - 1));
	assign stat.sect_last  = (soff_q == 13'(BANK_BYTES - 1)) && (i_q == 6'(SECTOR_BANKS - 1));
	assign stat.pend_last  = ((p_q + 7'd1) == cnt_q);
	assign stat.out_busy   = out_valid_q;

	// execute one access against the state left after any erase commit
	always_comb begin
		rd_n       = 8'h00;
		mode_n     = mode_q;
		step_n     = step_q;
		tog_n      = tog_q;
		cnt_n      = cnt_q;
		ex_cell_we = 1'b0;
		pend_we    = 1'b0;
		pend_wa    = cnt_q[5:0];
		case (cmd_q)
			CMD_BUS_RD: begin
				case (mode_q)
					MODE_READ:    rd_n = in_range ? cell_rd : 8'h00;
					MODE_AUTOSEL: begin
						if (off_q == 13'd0) begin
							rd_n = 8'h01;
						end else if (off_q == 13'd1) begin
							rd_n = 8'hA4;
						end
					end
					MODE_CHIP_ERASE, MODE_SECT_ERASE: begin
						tog_n = ~tog_q;
						rd_n  = {1'b0, ~tog_q, 6'b0};
					end
					MODE_SECT_SUSP, MODE_CHIP_SUSP: rd_n = {1'b1, tog_q, 6'b001000};
					default: rd_n = 8'h00;
				endcase
			end
			CMD_BUS_WR: begin
				case (mode_q)
					MODE_READ: begin
						if (over(stamp_q, last_q, timeout_q)) begin
							step_n = UL_IDLE;
						end
					end
					MODE_AUTOSEL: begin
						if (data_q == 8'hF0) begin
							mode_n = MODE_READ;
							step_n = UL_IDLE;
						end
					end
					MODE_PROGRAM: begin
						ex_cell_we = in_range;
						mode_n     = MODE_READ;
						step_n     = UL_IDLE;
					end
					MODE_CHIP_ERASE: begin
						if (data_q == 8'hB0) begin
							mode_n = MODE_CHIP_SUSP;
						end else begin
							mode_n = MODE_READ;
							step_n = UL_IDLE;
						end
					end
					MODE_SECT_ERASE: begin
						if (data_q == 8'hB0) begin
							mode_n = MODE_SECT_SUSP;
						end else if ((off_q == 13'd0) && (cnt_q < PEND_MAX_V)) begin
							pend_we = 1'b1;
							cnt_n   = cnt_q + 7'd1;
						end
					end
					MODE_SECT_SUSP: if (data_q == 8'h30) mode_n = MODE_SECT_ERASE;
					MODE_CHIP_SUSP: if (data_q == 8'h30) mode_n = MODE_CHIP_ERASE;
					default: ;
				endcase
				case (step_n)
					UL_IDLE: if (is555 && data_q == 8'hAA) step_n = UL_AA;
					UL_AA: begin
						if (is2aa && data_q == 8'h55) step_n = UL_55;
						else if (is555 && data_q == 8'hAA) step_n = UL_AA;
						else step_n = UL_IDLE;
					end
					UL_55: begin
						if (!is555) begin
							step_n = UL_IDLE;
						end else if (data_q == 8'hF0) begin
							mode_n = MODE_READ;
							step_n = UL_IDLE;
						end else if (data_q == 8'h90) begin
							mode_n = MODE_AUTOSEL;
							step_n = UL_IDLE;
						end else if (data_q == 8'hA0) begin
							mode_n = MODE_PROGRAM;
							step_n = UL_LOCKED;
						end else if (data_q == 8'h80) begin
							step_n = UL_80;
						end else if (data_q == 8'hAA) begin
							step_n = UL_AA;
						end else begin
							step_n = UL_IDLE;
						end
					end
					UL_80: step_n = (is555 && data_q == 8'hAA) ? UL_80AA : UL_IDLE;
					UL_80AA: begin
						if (is2aa && data_q == 8'h55) step_n = UL_8055;
						else if (is555 && data_q == 8'hAA) step_n = UL_AA;
						else step_n = UL_IDLE;
					end
					UL_8055: begin
						if (is555 && data_q == 8'h10) begin
							mode_n = MODE_CHIP_ERASE;
							step_n = UL_LOCKED;
							tog_n  = 1'b0;
						end else if (is555 && data_q == 8'hAA) begin
							step_n = UL_AA;
						end else if (data_q == 8'h30) begin
							mode_n  = MODE_SECT_ERASE;
							step_n  = UL_LOCKED;
							tog_n   = 1'b0;
							pend_we = 1'b1;
							pend_wa = 6'd0;
							cnt_n   = 7'd1;
						end else begin
							step_n = UL_IDLE;
						end
					end
					default: ;
				endcase
			end
			CMD_MON_RD: rd_n = in_range ? cell_rd : 8'h00;
			CMD_MON_WR: ex_cell_we = in_range;
			default: ;
		endcase
	end

	// cell write port: erase walks or the AND of an access
	always_comb begin
		cell_we = 1'b0;
		cell_wa = item_addr;
		cell_wd = cell_rd & data_q;
		if (cmd.fill_all) begin
			cell_we = 1'b1;
			cell_wa = sweep_q;
			cell_wd = 8'hFF;
		end else if (cmd.fill_sect) begin
			cell_we = ({1'b0, sbank} < BANK_COUNT_V);
			cell_wa = sect_addr;
			cell_wd = 8'hFF;
		end else if (cmd.exec) begin
			cell_we = ex_cell_we;
		end
	end

	nfcc_ram #(.WIDTH(8), .DEPTH(CELL_DEPTH)) u_cells (
		.clk   (clk),
		.we    (cell_we),
		.waddr (cell_wa),
		.wdata (cell_wd),
		.raddr (item_addr),
		.rdata (cell_rd)
	);

	nfcc_ram #(.WIDTH(6), .DEPTH(PEND_MAX)) u_pend (
		.clk   (clk),
		.we    (cmd.exec && pend_we),
		.waddr (pend_wa),
		.wdata (bank_q),
		.raddr (p_q[5:0]),
		.rdata (pend_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			cmd_q   <= in_command;
			bank_q  <= in_bank;
			off_q   <= in_offset;
			data_q  <= in_write_data;
			stamp_q <= in_stamp;
		end
		if (cmd.pend_load) begin
			base_q <= pend_rd;
		end
		if (cmd.exec) begin
			out_rd_q   <= rd_n;
			out_mode_q <= mode_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q     <= 16'd80;
			timeout_q   <= 16'd200;
			mode_q      <= MODE_READ;
			step_q      <= UL_IDLE;
			tog_q       <= 1'b0;
			last_q      <= '0;
			cnt_q       <= '0;
			sweep_q     <= '0;
			p_q         <= '0;
			i_q         <= '0;
			soff_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_ERASE_DELAY) delay_q <= cfg_data;
				else timeout_q <= cfg_data;
			end
			if (cmd.take) begin
				sweep_q <= '0;
				p_q     <= '0;
			end
			if (cmd.fill_all) begin
				sweep_q <= sweep_q + CELL_AW'(1);
			end
			if (cmd.pend_load) begin
				i_q    <= '0;
				soff_q <= '0;
			end
			if (cmd.fill_sect) begin
				if (soff_q == 13'(BANK_BYTES - 1)) begin
					soff_q <= '0;
					i_q    <= i_q + 6'd1;
				end else begin
					soff_q <= soff_q + 13'd1;
				end
			end
			if (cmd.pend_next) begin
				p_q <= p_q + 7'd1;
			end
			if (cmd.commit) begin
				mode_q <= MODE_READ;
				step_q <= UL_IDLE;
			end
			if (cmd.exec) begin
				mode_q <= mode_n;
				step_q <= step_n;
				tog_q  <= tog_n;
				cnt_q  <= cnt_n;
				if (cmd_q == CMD_BUS_WR) begin
					last_q <= stamp_q;
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_read_data = out_rd_q;
	assign out_mode_now  = out_mode_q;

endmodule
